// File: rtl/tlbc_pkg.sv
package tlbc_pkg;

  // Sample and field widths
  localparam int SAMPLE_W  = 12;
  localparam int SAMPLE_MAX = 4095;
  localparam int A_W       = 25;   // averaged temperature times 5447
  localparam int NI_W      = 7;
  localparam int RATE_W    = 10;
  localparam int DUTY_W    = 10;
  localparam int TENTHS_W  = 13;
  localparam int SET_W     = 10;
  localparam int CFG_IDX_W = 1;

  localparam int SAMPLES_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 1'd1;

  localparam logic [SET_W-1:0] SETPOINT_RESET = 10'd250;

  // Motor direction codes
  localparam logic [1:0] DIR_HOLD = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  // Step rates in steps per second
  localparam logic [RATE_W-1:0] RATE_SLOW = 10'd100;
  localparam logic [RATE_W-1:0] RATE_MED  = 10'd300;
  localparam logic [RATE_W-1:0] RATE_FAST = 10'd600;

  localparam logic [12:0] TEMP_SCALE = 13'd5447;

  // floor(x*100/4095) as (x*ILLUM_MULT) >> ILLUM_SHIFT, exact for x below 4096
  localparam int ILLUM_SHIFT = 31;
  localparam logic [25:0] ILLUM_MULT =
    26'(100 * (((64'd1 << ILLUM_SHIFT) + 64'd4094) / 64'd4095));

  // floor(a/4095) as (a*TENTHS_MULT) >> TENTHS_SHIFT, exact for a below 2**25
  localparam int TENTHS_SHIFT = 37;
  localparam logic [25:0] TENTHS_MULT =
    26'(((64'd1 << TENTHS_SHIFT) + 64'd4094) / 64'd4095);

  // Band offsets in tenths, scaled by 4095
  localparam logic [A_W-1:0] OFS_10 = 25'd40950;
  localparam logic [A_W-1:0] OFS_30 = 25'd122850;
  localparam logic [A_W-1:0] OFS_50 = 25'd204750;

  typedef struct packed {
    logic [SAMPLE_W-1:0] temp;
    logic [SAMPLE_W-1:0] light;
  } avg_t;

  typedef struct packed {
    logic [A_W-1:0]  a;
    logic [NI_W-1:0] q;   // averaged light times 100 over 4095
  } scaled_t;

  typedef struct packed {
    logic                 heater_on;
    logic [1:0]           motor_direction;
    logic [RATE_W-1:0]    step_rate;
    logic [NI_W-1:0]      illumination_percent;
    logic [NI_W-1:0]      led_level;
    logic [DUTY_W-1:0]    pwm_duty;
    logic [TENTHS_W-1:0]  temperature_tenths;
  } result_t;

  // Map illumination percentage to LED brightness band
  function automatic logic [NI_W-1:0] led_band(input logic [NI_W-1:0] ni);
    logic [NI_W-1:0] led;
    if (ni < 7'd20)      led = 7'd100;
    else if (ni < 7'd30) led = 7'd80;
    else if (ni < 7'd40) led = 7'd60;
    else if (ni < 7'd60) led = 7'd50;
    else if (ni < 7'd80) led = 7'd30;
    else                 led = 7'd0;
    return led;
  endfunction

  // (100 - led)*1023/100, truncated, for each band
  function automatic logic [DUTY_W-1:0] band_duty(input logic [NI_W-1:0] led);
    logic [DUTY_W-1:0] duty;
    case (led)
      7'd100:  duty = 10'd0;
      7'd80:   duty = 10'd204;
      7'd60:   duty = 10'd409;
      7'd50:   duty = 10'd511;
      7'd30:   duty = 10'd716;
      default: duty = 10'd1023;
    endcase
    return duty;
  endfunction

endpackage

// File: rtl/tlbc_accum.sv
module tlbc_accum #(
  parameter int SAMPLES_PER_AVERAGE = tlbc_pkg::SAMPLES_DEF,
  localparam int SUM_W = $clog2(SAMPLES_PER_AVERAGE * tlbc_pkg::SAMPLE_MAX + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          enable,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tlbc_pkg::SAMPLE_W-1:0] temp_sample,
  input  logic [tlbc_pkg::SAMPLE_W-1:0] light_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SUM_W-1:0]              temp_total,
  output logic [SUM_W-1:0]              light_total
);
  import tlbc_pkg::*;

  localparam int CNT_W = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;

  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] temp_sum, light_sum;
  logic [SUM_W-1:0] temp_sum_next, light_sum_next;
  logic             take, last;

  assign in_ready       = !out_valid || out_ready;
  assign take           = in_valid && in_ready;
  assign last           = (count == CNT_W'(SAMPLES_PER_AVERAGE - 1));
  assign temp_sum_next  = temp_sum + SUM_W'(temp_sample);
  assign light_sum_next = light_sum + SUM_W'(light_sample);

  // Accumulate, clear on a dropped request, hand over the full sums
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      temp_sum  <= '0;
      light_sum <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (!enable || last) begin
          count     <= '0;
          temp_sum  <= '0;
          light_sum <= '0;
          if (enable) begin
            out_valid <= 1'b1;
          end
        end else begin
          count     <= count + CNT_W'(1);
          temp_sum  <= temp_sum_next;
          light_sum <= light_sum_next;
        end
      end
    end
  end

  // Capture the totals that close an average
  always_ff @(posedge clk) begin
    if (take && enable && last) begin
      temp_total  <= temp_sum_next;
      light_total <= light_sum_next;
    end
  end

endmodule

// File: rtl/tlbc_average.sv
module tlbc_average #(
  parameter int SAMPLES_PER_AVERAGE = tlbc_pkg::SAMPLES_DEF,
  localparam int SUM_W = $clog2(SAMPLES_PER_AVERAGE * tlbc_pkg::SAMPLE_MAX + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SUM_W-1:0]     temp_total,
  input  logic [SUM_W-1:0]     light_total,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tlbc_pkg::avg_t       avg
);
  import tlbc_pkg::*;

  // Divide by the sample count through a reciprocal, exact over the sum range
  localparam int L_W   = $clog2(SAMPLES_PER_AVERAGE);
  localparam int SHIFT = SUM_W + L_W;
  localparam int M_W   = SUM_W + 2;
  localparam int P_W   = SUM_W + M_W;
  localparam logic [M_W-1:0] RECIP =
    M_W'(((64'd1 << SHIFT) + 64'(SAMPLES_PER_AVERAGE - 1)) / 64'(SAMPLES_PER_AVERAGE));

  logic [P_W-1:0] temp_prod, light_prod;
  logic           take;

  assign in_ready   = !out_valid || out_ready;
  assign take       = in_valid && in_ready;
  assign temp_prod  = P_W'(temp_total) * P_W'(RECIP);
  assign light_prod = P_W'(light_total) * P_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      avg.temp  <= temp_prod[SHIFT +: SAMPLE_W];
      avg.light <= light_prod[SHIFT +: SAMPLE_W];
    end
  end

endmodule

// File: rtl/tlbc_scale.sv
module tlbc_scale (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tlbc_pkg::avg_t    avg,
  output logic              out_valid,
  input  logic              out_ready,
  output tlbc_pkg::scaled_t scaled
);
  import tlbc_pkg::*;

  localparam int LP_W = SAMPLE_W + 26;

  logic [A_W-1:0]  a_next;
  logic [LP_W-1:0] light_prod;
  logic            take;

  assign in_ready   = !out_valid || out_ready;
  assign take       = in_valid && in_ready;
  // Temperature scaled to tenths times 4095, and light to a percentage
  assign a_next     = A_W'(avg.temp) * A_W'(TEMP_SCALE);
  assign light_prod = LP_W'(avg.light) * LP_W'(ILLUM_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      scaled.a <= a_next;
      scaled.q <= light_prod[ILLUM_SHIFT +: NI_W];
    end
  end

endmodule

// File: rtl/tlbc_band.sv
module tlbc_band (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [tlbc_pkg::SET_W-1:0] setpoint,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tlbc_pkg::scaled_t          scaled,
  output logic                       out_valid,
  input  logic                       out_ready,
  output tlbc_pkg::result_t          result
);
  import tlbc_pkg::*;

  localparam int TP_W = A_W + 26;

  logic [A_W-1:0]  set_scaled;
  logic [TP_W-1:0] tenths_prod;
  logic [NI_W-1:0] ni, led;
  logic            heat, idle, vent_low, vent_med;
  logic            take;
  result_t         result_next;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Setpoint times 4095 as a shift and subtract
  assign set_scaled = {3'b000, setpoint, 12'b0} - A_W'(setpoint);

  assign heat     = (setpoint >= SET_W'(10)) && (scaled.a < set_scaled - OFS_10);
  assign idle     = scaled.a <= set_scaled + OFS_10;
  assign vent_low = scaled.a < set_scaled + OFS_30;
  assign vent_med = scaled.a <= set_scaled + OFS_50;

  assign tenths_prod = TP_W'(scaled.a) * TP_W'(TENTHS_MULT);
  assign ni          = NI_W'(100) - scaled.q;
  assign led         = led_band(ni);

  // Pick the band and assemble the result
  always_comb begin
    result_next                      = '0;
    result_next.illumination_percent = ni;
    result_next.led_level            = led;
    result_next.pwm_duty             = band_duty(led);
    result_next.temperature_tenths   = tenths_prod[TENTHS_SHIFT +: TENTHS_W];
    if (heat) begin
      result_next.heater_on       = 1'b1;
      result_next.motor_direction = DIR_CW;
      result_next.step_rate       = RATE_SLOW;
    end else if (idle) begin
      result_next.motor_direction = DIR_HOLD;
      result_next.step_rate       = RATE_SLOW;
    end else if (vent_low) begin
      result_next.motor_direction = DIR_CCW;
      result_next.step_rate       = RATE_SLOW;
    end else if (vent_med) begin
      result_next.motor_direction = DIR_CCW;
      result_next.step_rate       = RATE_MED;
    end else begin
      result_next.motor_direction = DIR_CCW;
      result_next.step_rate       = RATE_FAST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

endmodule

// File: rtl/thermal_light_band_controller_top.sv
// Thermal and light band controller. Sample pairs are taken at one per clock
// cycle while s_tready is high; the four register stages (accumulator, averaging
// reciprocal multiply, scaling multiply, band decision and output register) each
// pass one request per cycle unless stalled, and a result is registered by the
// averaging, scaling and band stages after the sample that completes an average
// of SAMPLES_PER_AVERAGE pairs. Backpressure on the result side ripples back
// stage by stage, and a stage with a free slot keeps accepting. While enable is
// low, accepted samples are dropped and the running sums and count are cleared.
// Write the setpoint and enable only when no average is in flight.
module thermal_light_band_controller_top #(
  parameter int SAMPLES_PER_AVERAGE = tlbc_pkg::SAMPLES_DEF,
  localparam int SUM_W = $clog2(SAMPLES_PER_AVERAGE * tlbc_pkg::SAMPLE_MAX + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tlbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlbc_pkg::SET_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // temperature_sample [11:0], light_sample [23:12]
  input  logic [23:0]                    s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // heater_on [0], motor_direction [2:1], step_rate [12:3],
  // illumination_percent [19:13], led_level [26:20], pwm_duty [36:27],
  // temperature_tenths [49:37], zero [55:50]
  output logic [55:0]                    m_tdata
);
  import tlbc_pkg::*;

  logic [SET_W-1:0] setpoint;
  logic             enable;

  logic             acc_valid, avg_ready;
  logic [SUM_W-1:0] temp_total, light_total;
  logic             avg_valid, scale_ready;
  avg_t             avg;
  logic             scale_valid, band_ready;
  scaled_t          scaled;
  result_t          result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= SETPOINT_RESET;
      enable   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETPOINT: setpoint <= cfg_data;
        REG_ENABLE:   enable   <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  tlbc_accum #(.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)) u_accum (
    .clk          (clk),
    .rst          (rst),
    .enable       (enable),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .temp_sample  (s_tdata[11:0]),
    .light_sample (s_tdata[23:12]),
    .out_valid    (acc_valid),
    .out_ready    (avg_ready),
    .temp_total   (temp_total),
    .light_total  (light_total)
  );

  tlbc_average #(.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)) u_average (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (acc_valid),
    .in_ready    (avg_ready),
    .temp_total  (temp_total),
    .light_total (light_total),
    .out_valid   (avg_valid),
    .out_ready   (scale_ready),
    .avg         (avg)
  );

  tlbc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (avg_valid),
    .in_ready  (scale_ready),
    .avg       (avg),
    .out_valid (scale_valid),
    .out_ready (band_ready),
    .scaled    (scaled)
  );

  tlbc_band u_band (
    .clk       (clk),
    .rst       (rst),
    .setpoint  (setpoint),
    .in_valid  (scale_valid),
    .in_ready  (band_ready),
    .scaled    (scaled),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

  // Pack the result fields from the lowest bit up
  assign m_tdata = {6'b000000,
                    result.temperature_tenths,
                    result.pwm_duty,
                    result.led_level,
                    result.illumination_percent,
                    result.step_rate,
                    result.motor_direction,
                    result.heater_on};

endmodule
